// File: sv/clp_pkg.sv
// shared constants, types and status codes of the line closest-approach block
// no dependencies
package clp_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int EPS_BITS       = 16;
  localparam int ADDR_BITS      = 3;
  localparam int MUL_CHUNK      = 32;
  localparam int MUL_LAT        = 5;

  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;
  localparam logic                REG_EPS   = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_B_DEGEN  = 2'd1,
    ST_A_DEGEN  = 2'd2,
    ST_PARALLEL = 2'd3
  } status_t;

endpackage

// File: sv/clp_mul.sv
// pipelined signed multiplier built from chunk partial products
// depends on clp_pkg
module clp_mul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH = clp_pkg::MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int RW = (NB + 1) * CH;
  localparam int TW = (NA + NB) * CH;

  logic [AW-1:0]    a_abs;
  logic [BW-1:0]    b_abs;
  logic [NA*CH-1:0] am_r;
  logic [NB*CH-1:0] bm_r;
  logic [3:0]       neg_r;
  logic [2*CH-1:0]  pp_r [NA][NB];
  logic [RW-1:0]    row_nxt [NA];
  logic [RW-1:0]    row_r [NA];
  logic [TW-1:0]    sum_nxt;
  logic [TW-1:0]    sum_r;
  logic [AW+BW-1:0] mag_w;
  logic signed [AW+BW-1:0] p_r;

  assign a_abs = a[AW-1] ? AW'(-a) : AW'(a);
  assign b_abs = b[BW-1] ? BW'(-b) : BW'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (j * CH));
      end
    end
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (TW'(row_r[i]) << (i * CH));
    end
  end

  assign mag_w = sum_r[AW+BW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= (NA*CH)'(a_abs);
      bm_r  <= (NB*CH)'(b_abs);
      neg_r <= {neg_r[2:0], a[AW-1] ^ b[BW-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= am_r[i*CH +: CH] * bm_r[j*CH +: CH];
        end
        row_r[i] <= row_nxt[i];
      end
      sum_r <= sum_nxt;
      p_r   <= neg_r[3] ? (AW+BW)'(-mag_w) : mag_w;
    end
  end

  assign p = p_r;

endmodule

// File: sv/clp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// no dependencies
module clp_div #(
  parameter int NW = 153,
  parameter int DW = 137,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          ovf
);

  localparam int HW   = NW - QW;
  localparam int CMPW = (HW > DW) ? HW : DW;

  logic [HW-1:0] hi_w;
  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [DW:0]   trial [QW+1];
  logic          fit   [QW+1];
  logic [DW-1:0] rem_nxt [QW+1];

  assign hi_w = n[NW-1:QW];

  always_comb begin
    trial[0]   = '0;
    fit[0]     = 1'b0;
    rem_nxt[0] = DW'(hi_w);
    for (int k = 1; k <= QW; k++) begin
      trial[k]   = {rem_r[k-1], lo_r[k-1][QW-1]};
      fit[k]     = trial[k] >= {1'b0, d_r[k-1]};
      rem_nxt[k] = fit[k] ? DW'(trial[k] - {1'b0, d_r[k-1]}) : DW'(trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem_nxt[0];
      lo_r[0]  <= n[QW-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= d;
      ovf_r[0] <= CMPW'(hi_w) >= CMPW'(d);
      for (int k = 1; k <= QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= {lo_r[k-1][QW-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][QW-2:0], fit[k]};
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign q   = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// File: sv/clp_dly.sv
// enable-gated delay line that carries side data alongside the pipeline
// no dependencies
module clp_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign dout = sr_r[DEPTH-1];

endmodule

// File: sv/closest_points_between_3d_lines.sv
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: rst_n synchronous active low clears valid bits and sets eps to 1
// top level; depends on clp_pkg, clp_mul, clp_div, clp_dly
module closest_points_between_3d_lines #(
  parameter int COORD_BITS = clp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = clp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_a1_x,
  input  logic signed [COORD_BITS-1:0]  in_a1_y,
  input  logic signed [COORD_BITS-1:0]  in_a1_z,
  input  logic signed [COORD_BITS-1:0]  in_a2_x,
  input  logic signed [COORD_BITS-1:0]  in_a2_y,
  input  logic signed [COORD_BITS-1:0]  in_a2_z,
  input  logic signed [COORD_BITS-1:0]  in_b1_x,
  input  logic signed [COORD_BITS-1:0]  in_b1_y,
  input  logic signed [COORD_BITS-1:0]  in_b1_z,
  input  logic signed [COORD_BITS-1:0]  in_b2_x,
  input  logic signed [COORD_BITS-1:0]  in_b2_y,
  input  logic signed [COORD_BITS-1:0]  in_b2_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic signed [COORD_BITS-1:0]  out_param_a,
  output logic signed [COORD_BITS-1:0]  out_param_b,
  output logic signed [COORD_BITS-1:0]  out_near_a_x,
  output logic signed [COORD_BITS-1:0]  out_near_a_y,
  output logic signed [COORD_BITS-1:0]  out_near_a_z,
  output logic signed [COORD_BITS-1:0]  out_near_b_x,
  output logic signed [COORD_BITS-1:0]  out_near_b_y,
  output logic signed [COORD_BITS-1:0]  out_near_b_z
);

  localparam int CW   = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int EB   = clp_pkg::EPS_BITS;
  localparam int DFW  = CW + 1;
  localparam int PPW  = 2 * DFW;
  localparam int DOTW = PPW + 2;
  localparam int PW   = 2 * DOTW + 1;
  localparam int LIMW = (PW > EB + 3 * F) ? PW : EB + 3 * F;
  localparam int P2W  = DOTW + CW;
  localparam int NS2W = P2W + 1;
  localparam int FPW  = CW + DFW;
  localparam int SW   = FPW - F + 1;
  localparam int LM   = clp_pkg::MUL_LAT;
  localparam int LD   = CW + 1;

  localparam int S_DIF = 1;
  localparam int S_PP  = 2;
  localparam int S_DOT = 3;
  localparam int S_DN  = S_DOT + LM + 1;
  localparam int S_DV  = S_DN + 1;
  localparam int S_MUA = S_DV + LD + 1;
  localparam int S_N2  = S_MUA + LM + 1;
  localparam int S_A2  = S_N2 + 1;
  localparam int S_MUB = S_A2 + LD + 1;
  localparam int S_PR  = S_MUB + 1;
  localparam int S_OUT = S_PR + 1;

  localparam logic signed [FPW-1:0] RND_V  = FPW'((64'sd1 <<< F) - 64'sd1);
  localparam logic signed [FPW-1:0] ZERO_V = '0;
  localparam logic signed [SW-1:0]  SMAX   = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0]  SMIN   = -SMAX - SW'(1);

  function automatic logic tiny(input logic signed [DFW-1:0] v0, v1, v2,
                                input logic [EB-1:0] e);
    logic [DFW-1:0] m0, m1, m2, ez;
    m0 = v0[DFW-1] ? DFW'(-v0) : DFW'(v0);
    m1 = v1[DFW-1] ? DFW'(-v1) : DFW'(v1);
    m2 = v2[DFW-1] ? DFW'(-v2) : DFW'(v2);
    ez = DFW'(e);
    return (v0 == '0 && v1 == '0 && v2 == '0) || (m0 < ez && m1 < ez && m2 < ez);
  endfunction

  function automatic logic signed [CW-1:0] sat_q(input logic [CW-1:0] q,
                                                 input logic ovf, input logic neg);
    logic [CW-1:0] lim, mag;
    lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    mag = (ovf || q > lim) ? lim : q;
    return neg ? signed'(CW'(-mag)) : signed'(mag);
  endfunction

  function automatic logic signed [CW-1:0] add_sat(input logic signed [CW-1:0] base,
                                                   input logic signed [FPW-1:0] p);
    logic signed [FPW-1:0] adj, sh;
    logic signed [SW-1:0]  sum;
    adj = p + (p[FPW-1] ? RND_V : ZERO_V);
    sh  = adj >>> F;
    sum = SW'(base) + SW'(sh);
    if (sum > SMAX) begin
      sum = SMAX;
    end else if (sum < SMIN) begin
      sum = SMIN;
    end
    return CW'(sum);
  endfunction

  // control and config
  logic [EB-1:0]    eps_r;
  logic [S_OUT:1]   vld_r;
  logic             en;

  assign pready    = 1'b1;
  assign out_valid = vld_r[S_OUT];
  assign en        = !vld_r[S_OUT] || out_ready;
  assign in_ready  = en;
  assign prdata    = (paddr[2] == clp_pkg::REG_EPS) ? 32'(eps_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= clp_pkg::EPS_RESET;
      vld_r <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == clp_pkg::REG_EPS) begin
        eps_r <= pwdata[EB-1:0];
      end
      if (en) begin
        vld_r <= {vld_r[S_OUT-1:1], in_valid};
      end
    end
  end

  // differences
  logic signed [CW-1:0]  a1_w [3], a2_w [3], b1_w [3], b2_w [3];
  logic signed [CW-1:0]  a1_r [3], b1_r [3];
  logic signed [DFW-1:0] d13_r [3], d43_r [3], d21_r [3];

  assign a1_w[0] = in_a1_x;
  assign a1_w[1] = in_a1_y;
  assign a1_w[2] = in_a1_z;
  assign a2_w[0] = in_a2_x;
  assign a2_w[1] = in_a2_y;
  assign a2_w[2] = in_a2_z;
  assign b1_w[0] = in_b1_x;
  assign b1_w[1] = in_b1_y;
  assign b1_w[2] = in_b1_z;
  assign b2_w[0] = in_b2_x;
  assign b2_w[1] = in_b2_y;
  assign b2_w[2] = in_b2_z;

  // dot products: 0 d1343, 1 d4321, 2 d1321, 3 d4343, 4 d2121
  logic signed [PPW-1:0]  pp_r [5][3];
  logic signed [DOTW-1:0] dot_r [5];
  logic [1:0]             st_pp_r;
  logic [1:0]             st_pre_w;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]  <= a1_w[i];
        b1_r[i]  <= b1_w[i];
        d13_r[i] <= DFW'(a1_w[i]) - DFW'(b1_w[i]);
        d43_r[i] <= DFW'(b2_w[i]) - DFW'(b1_w[i]);
        d21_r[i] <= DFW'(a2_w[i]) - DFW'(a1_w[i]);
        pp_r[0][i] <= PPW'(d13_r[i]) * PPW'(d43_r[i]);
        pp_r[1][i] <= PPW'(d43_r[i]) * PPW'(d21_r[i]);
        pp_r[2][i] <= PPW'(d13_r[i]) * PPW'(d21_r[i]);
        pp_r[3][i] <= PPW'(d43_r[i]) * PPW'(d43_r[i]);
        pp_r[4][i] <= PPW'(d21_r[i]) * PPW'(d21_r[i]);
      end
      if (tiny(d43_r[0], d43_r[1], d43_r[2], eps_r)) begin
        st_pp_r <= clp_pkg::ST_B_DEGEN;
      end else if (tiny(d21_r[0], d21_r[1], d21_r[2], eps_r)) begin
        st_pp_r <= clp_pkg::ST_A_DEGEN;
      end else begin
        st_pp_r <= clp_pkg::ST_OK;
      end
      for (int k = 0; k < 5; k++) begin
        dot_r[k] <= DOTW'(pp_r[k][0]) + DOTW'(pp_r[k][1]) + DOTW'(pp_r[k][2]);
      end
    end
  end

  // denominator and numerator of mua
  logic signed [2*DOTW-1:0] mp_w [4];
  logic signed [PW-1:0]     denom_r, numer_r;
  logic [PW-1:0]            dmag_w, nmag_w;
  logic [LIMW-1:0]          lim_w;
  logic [PW-1:0]            dmag_r;
  logic [PW+F-1:0]          nmag_r;
  logic                     qneg_r;
  logic [1:0]               st_r;

  clp_mul #(.AW(DOTW), .BW(DOTW)) u_mul_dd (
    .clk, .en, .a(dot_r[4]), .b(dot_r[3]), .p(mp_w[0]));
  clp_mul #(.AW(DOTW), .BW(DOTW)) u_mul_cc (
    .clk, .en, .a(dot_r[1]), .b(dot_r[1]), .p(mp_w[1]));
  clp_mul #(.AW(DOTW), .BW(DOTW)) u_mul_ac (
    .clk, .en, .a(dot_r[0]), .b(dot_r[1]), .p(mp_w[2]));
  clp_mul #(.AW(DOTW), .BW(DOTW)) u_mul_bd (
    .clk, .en, .a(dot_r[2]), .b(dot_r[3]), .p(mp_w[3]));

  clp_dly #(.W(2), .DEPTH(S_DN - S_PP)) u_dly_stpre (
    .clk, .en, .din(st_pp_r), .dout(st_pre_w));

  assign dmag_w = denom_r[PW-1] ? PW'(-denom_r) : PW'(denom_r);
  assign nmag_w = numer_r[PW-1] ? PW'(-numer_r) : PW'(numer_r);
  assign lim_w  = LIMW'(eps_r) << (3 * F);

  always_ff @(posedge clk) begin
    if (en) begin
      denom_r <= PW'(mp_w[0]) - PW'(mp_w[1]);
      numer_r <= PW'(mp_w[2]) - PW'(mp_w[3]);
      dmag_r  <= dmag_w;
      nmag_r  <= {nmag_w, {F{1'b0}}};
      qneg_r  <= numer_r[PW-1] ^ denom_r[PW-1];
      if (st_pre_w != clp_pkg::ST_OK) begin
        st_r <= st_pre_w;
      end else if (dmag_w == '0 || LIMW'(dmag_w) < lim_w) begin
        st_r <= clp_pkg::ST_PARALLEL;
      end else begin
        st_r <= clp_pkg::ST_OK;
      end
    end
  end

  // mua
  logic [CW-1:0]        q1_w;
  logic                 ovf1_w, qneg_w;
  logic signed [CW-1:0] mua_r;

  clp_div #(.NW(PW + F), .DW(PW), .QW(CW)) u_div_a (
    .clk, .en, .n(nmag_r), .d(dmag_r), .q(q1_w), .ovf(ovf1_w));
  clp_dly #(.W(1), .DEPTH(LD)) u_dly_qneg (
    .clk, .en, .din(qneg_r), .dout(qneg_w));

  // mub
  logic signed [DOTW-1:0] d4321_dl, d1343_dl, d4343_dl;
  logic signed [P2W-1:0]  p2_w;
  logic signed [NS2W-1:0] num2_r;
  logic [NS2W-1:0]        n2mag_r;
  logic [DOTW-1:0]        d2mag_r;
  logic                   neg2_r, neg2_w, ovf2_w;
  logic [CW-1:0]          q2_w;
  logic signed [CW-1:0]   mub_r;

  clp_dly #(.W(DOTW), .DEPTH(S_MUA - S_DOT)) u_dly_d4321 (
    .clk, .en, .din(dot_r[1]), .dout(d4321_dl));
  clp_dly #(.W(DOTW), .DEPTH(S_N2 - 1 - S_DOT)) u_dly_d1343 (
    .clk, .en, .din(dot_r[0]), .dout(d1343_dl));
  clp_dly #(.W(DOTW), .DEPTH(S_N2 - S_DOT)) u_dly_d4343 (
    .clk, .en, .din(dot_r[3]), .dout(d4343_dl));

  clp_mul #(.AW(DOTW), .BW(CW)) u_mul_mb (
    .clk, .en, .a(d4321_dl), .b(mua_r), .p(p2_w));

  clp_div #(.NW(NS2W), .DW(DOTW), .QW(CW)) u_div_b (
    .clk, .en, .n(n2mag_r), .d(d2mag_r), .q(q2_w), .ovf(ovf2_w));
  clp_dly #(.W(1), .DEPTH(LD)) u_dly_neg2 (
    .clk, .en, .din(neg2_r), .dout(neg2_w));

  always_ff @(posedge clk) begin
    if (en) begin
      mua_r   <= sat_q(q1_w, ovf1_w, qneg_w);
      num2_r  <= (NS2W'(d1343_dl) <<< F) + NS2W'(p2_w);
      n2mag_r <= num2_r[NS2W-1] ? NS2W'(-num2_r) : NS2W'(num2_r);
      neg2_r  <= num2_r[NS2W-1];
      d2mag_r <= d4343_dl;
      mub_r   <= sat_q(q2_w, ovf2_w, neg2_w);
    end
  end

  // closest points
  logic signed [CW-1:0]  mua_dl;
  logic signed [CW-1:0]  a1_dl [3], b1_dl [3];
  logic signed [DFW-1:0] d21_dl [3], d43_dl [3];
  logic signed [FPW-1:0] pa_r [3], pb_r [3];
  logic [1:0]            st_dl;

  clp_dly #(.W(CW), .DEPTH(S_MUB - S_MUA)) u_dly_mua (
    .clk, .en, .din(mua_r), .dout(mua_dl));
  clp_dly #(.W(2), .DEPTH(S_PR - S_DV)) u_dly_st (
    .clk, .en, .din(st_r), .dout(st_dl));

  for (genvar i = 0; i < 3; i++) begin : g_side
    clp_dly #(.W(CW), .DEPTH(S_PR - S_DIF)) u_dly_a1 (
      .clk, .en, .din(a1_r[i]), .dout(a1_dl[i]));
    clp_dly #(.W(CW), .DEPTH(S_PR - S_DIF)) u_dly_b1 (
      .clk, .en, .din(b1_r[i]), .dout(b1_dl[i]));
    clp_dly #(.W(DFW), .DEPTH(S_MUB - S_DIF)) u_dly_d21 (
      .clk, .en, .din(d21_r[i]), .dout(d21_dl[i]));
    clp_dly #(.W(DFW), .DEPTH(S_MUB - S_DIF)) u_dly_d43 (
      .clk, .en, .din(d43_r[i]), .dout(d43_dl[i]));
  end

  logic [1:0]           st_out_r;
  logic signed [CW-1:0] mua_out_r, mub_out_r;
  logic signed [CW-1:0] pa_out_r [3], pb_out_r [3];
  logic                 ok_w;

  assign ok_w = (st_dl == clp_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i]     <= FPW'(mua_dl) * FPW'(d21_dl[i]);
        pb_r[i]     <= FPW'(mub_r) * FPW'(d43_dl[i]);
        pa_out_r[i] <= ok_w ? add_sat(a1_dl[i], pa_r[i]) : '0;
        pb_out_r[i] <= ok_w ? add_sat(b1_dl[i], pb_r[i]) : '0;
      end
      mua_out_r <= mua_dl;
      mub_out_r <= mub_r;
      st_out_r  <= st_dl;
    end
  end

  logic signed [CW-1:0] mua_pr_r, mub_pr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mua_pr_r <= ok_w ? mua_out_r : '0;
      mub_pr_r <= ok_w ? mub_out_r : '0;
    end
  end

  assign out_status   = st_out_r;
  assign out_param_a  = mua_pr_r;
  assign out_param_b  = mub_pr_r;
  assign out_near_a_x = pa_out_r[0];
  assign out_near_a_y = pa_out_r[1];
  assign out_near_a_z = pa_out_r[2];
  assign out_near_b_x = pb_out_r[0];
  assign out_near_b_y = pb_out_r[1];
  assign out_near_b_z = pb_out_r[2];

endmodule

// File: sv/clp_chk.sv
// port-level checks for the line closest-approach block, bound to the top level
// depends on clp_pkg and closest_points_between_3d_lines
module clp_chk #(
  parameter int COORD_BITS = clp_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic signed [COORD_BITS-1:0] out_param_a,
  input logic signed [COORD_BITS-1:0] out_param_b,
  input logic signed [COORD_BITS-1:0] out_near_a_x,
  input logic signed [COORD_BITS-1:0] out_near_a_y,
  input logic signed [COORD_BITS-1:0] out_near_a_z,
  input logic signed [COORD_BITS-1:0] out_near_b_x,
  input logic signed [COORD_BITS-1:0] out_near_b_y,
  input logic signed [COORD_BITS-1:0] out_near_b_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_param_a)
      && $stable(out_param_b) && $stable(out_near_a_x) && $stable(out_near_b_z))
    else $error("stalled item changed");

  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != clp_pkg::ST_OK |-> out_param_a == '0
      && out_param_b == '0 && out_near_a_x == '0 && out_near_a_y == '0
      && out_near_a_z == '0 && out_near_b_x == '0 && out_near_b_y == '0
      && out_near_b_z == '0)
    else $error("failed item carries nonzero results");

endmodule

bind closest_points_between_3d_lines clp_chk #(.COORD_BITS(COORD_BITS)) u_clp_chk (.*);
